// File: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, character codes and classifier functions of the tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  typedef enum logic [2:0] {
    K_EOF    = 3'd0,
    K_LPAREN = 3'd1,
    K_RPAREN = 3'd2,
    K_QUOTE  = 3'd3,
    K_STRING = 3'd4,
    K_NUMBER = 3'd5,
    K_SYMBOL = 3'd6,
    K_ERROR  = 3'd7
  } tok_kind_e;

  localparam int PosOutW = 16;   // width of the line and col ports
  localparam int MaxRes  = 4;    // most results that one item can cause
  localparam int ResCntW = 3;    // holds 0 .. MaxRes
  localparam int QDepth  = 2;    // bundles held between lexer and output

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerT = 8'h74;

  typedef struct packed {
    tok_kind_e          kind;
    logic               has_char;
    logic [7:0]         text_char;
    logic               last;
    logic [PosOutW-1:0] line;
    logic [PosOutW-1:0] col;
  } tok_t;

  // all results of one item, slot 0 first
  typedef struct packed {
    logic [ResCntW-1:0]   cnt;
    tok_t [MaxRes-1:0]    tok;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // + - * / < > = ! ? _ . $ : %
  function automatic logic is_sign(input logic [7:0] c);
    return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3E, 8'h3D,
                     8'h21, 8'h3F, 8'h5F, 8'h2E, 8'h24, 8'h3A, 8'h25};
  endfunction

  function automatic logic sym_first(input logic [7:0] c);
    return is_alpha(c) || is_sign(c);
  endfunction

  function automatic logic sym_next(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || is_sign(c);
  endfunction

  function automatic tok_t mk_tok(input tok_kind_e kind, input logic has,
                                  input logic [7:0] c, input logic last,
                                  input logic [PosOutW-1:0] line,
                                  input logic [PosOutW-1:0] col);
    tok_t t;
    t.kind      = kind;
    t.has_char  = has;
    t.text_char = has ? c : 8'h00;
    t.last      = last;
    t.line      = line;
    t.col       = col;
    return t;
  endfunction

endpackage

// File: rtl/stok_front.sv
// ----------------------------------------------------------------------------
// stok_front
// Lexer front end: takes one byte per cycle while the queue is not full, updates
// the scanner state and packs the results of the byte into one bundle for the queue.
// ----------------------------------------------------------------------------
module stok_front import stok_pkg::*; #(
  parameter int MAX_TEXT      = 255,
  parameter int POSITION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] ch_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output logic       push_o,
  output bundle_t    push_data_o
);

  localparam int TW = $clog2(MAX_TEXT + 1);
  localparam logic [TW-1:0] TextMax = TW'(MAX_TEXT);

  typedef enum logic [3:0] {
    M_IDLE,
    M_COMMENT,
    M_STRING,
    M_ESCAPE,
    M_NUMBER,
    M_MINUS,
    M_SYMBOL
  } lex_mode_e;

  lex_mode_e                mode_q, mode_d;
  logic [TW-1:0]            cnt_q, cnt_d;
  logic                     dot_q, dot_d;
  logic                     halt_q, halt_d;
  logic [POSITION_BITS-1:0] cl_q, cl_d, cc_q, cc_d;
  logic [POSITION_BITS-1:0] sl_q, sl_d, sc_q, sc_d;

  logic                     accept;
  logic                     disp, symb;
  logic [ResCntW-1:0]       k;
  tok_t [MaxRes-1:0]        res;
  logic [7:0]               c;
  logic [7:0]               esc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = ch_i;
  assign esc        = (c == ChLowerN) ? ChLf : ((c == ChLowerT) ? ChTab : c);

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    dot_d  = dot_q;
    halt_d = halt_q;
    cl_d   = cl_q;
    cc_d   = cc_q;
    sl_d   = sl_q;
    sc_d   = sc_q;
    disp   = 1'b0;
    symb   = 1'b0;
    k      = '0;
    res    = '0;

    if (end_of_input_i) begin
      case (mode_q)
        M_STRING: begin
          res[k[1:0]] = mk_tok(K_STRING, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end
        M_ESCAPE: begin
          // a dangling backslash is kept as text
          if (cnt_d < TextMax) begin
            cnt_d = cnt_d + 1'b1;
            res[k[1:0]] = mk_tok(K_STRING, 1'b1, ChBslash, 1'b0,
                                 PosOutW'(sl_d), PosOutW'(sc_d));
            k = k + 1'b1;
          end
          res[k[1:0]] = mk_tok(K_STRING, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end
        M_NUMBER: begin
          res[k[1:0]] = mk_tok(K_NUMBER, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end
        M_MINUS: begin
          if (cnt_d < TextMax) begin
            cnt_d = cnt_d + 1'b1;
            res[k[1:0]] = mk_tok(K_SYMBOL, 1'b1, ChMinus, 1'b0,
                                 PosOutW'(sl_d), PosOutW'(sc_d));
            k = k + 1'b1;
          end
          res[k[1:0]] = mk_tok(K_SYMBOL, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end
        M_SYMBOL: begin
          res[k[1:0]] = mk_tok(K_SYMBOL, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
      cnt_d  = '0;
      dot_d  = 1'b0;
      sl_d   = cl_q;
      sc_d   = cc_q;
      res[k[1:0]] = mk_tok(K_EOF, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
      k = k + 1'b1;
    end else begin
      case (mode_q)
        M_COMMENT: begin
          if (c == ChLf) mode_d = M_IDLE;
        end
        M_STRING: begin
          if (c == ChDquote) begin
            mode_d = M_IDLE;
            res[k[1:0]] = mk_tok(K_STRING, 1'b0, 8'h00, 1'b1,
                                 PosOutW'(sl_d), PosOutW'(sc_d));
            k = k + 1'b1;
          end else if (c == ChBslash) begin
            mode_d = M_ESCAPE;
          end else if (cnt_d < TextMax) begin
            cnt_d = cnt_d + 1'b1;
            res[k[1:0]] = mk_tok(K_STRING, 1'b1, c, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
            k = k + 1'b1;
          end
        end
        M_ESCAPE: begin
          if (cnt_d < TextMax) begin
            cnt_d = cnt_d + 1'b1;
            res[k[1:0]] = mk_tok(K_STRING, 1'b1, esc, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
            k = k + 1'b1;
          end
          mode_d = M_STRING;
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            if (cnt_d < TextMax) begin
              cnt_d = cnt_d + 1'b1;
              res[k[1:0]] = mk_tok(K_NUMBER, 1'b1, c, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
              k = k + 1'b1;
            end
          end else if (c == ChDot) begin
            if (dot_d) begin
              // second dot closes the number and is dropped
              mode_d = M_IDLE;
              res[k[1:0]] = mk_tok(K_NUMBER, 1'b0, 8'h00, 1'b1,
                                   PosOutW'(sl_d), PosOutW'(sc_d));
              k = k + 1'b1;
            end else begin
              dot_d = 1'b1;
              if (cnt_d < TextMax) begin
                cnt_d = cnt_d + 1'b1;
                res[k[1:0]] = mk_tok(K_NUMBER, 1'b1, c, 1'b0,
                                     PosOutW'(sl_d), PosOutW'(sc_d));
                k = k + 1'b1;
              end
            end
          end else begin
            mode_d = M_IDLE;
            res[k[1:0]] = mk_tok(K_NUMBER, 1'b0, 8'h00, 1'b1,
                                 PosOutW'(sl_d), PosOutW'(sc_d));
            k = k + 1'b1;
            disp = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_digit(c)) begin
            if (cnt_d < TextMax) begin
              cnt_d = cnt_d + 1'b1;
              res[k[1:0]] = mk_tok(K_NUMBER, 1'b1, ChMinus, 1'b0,
                                   PosOutW'(sl_d), PosOutW'(sc_d));
              k = k + 1'b1;
            end
            if (cnt_d < TextMax) begin
              cnt_d = cnt_d + 1'b1;
              res[k[1:0]] = mk_tok(K_NUMBER, 1'b1, c, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
              k = k + 1'b1;
            end
            mode_d = M_NUMBER;
          end else begin
            // lone minus turns into a symbol
            if (cnt_d < TextMax) begin
              cnt_d = cnt_d + 1'b1;
              res[k[1:0]] = mk_tok(K_SYMBOL, 1'b1, ChMinus, 1'b0,
                                   PosOutW'(sl_d), PosOutW'(sc_d));
              k = k + 1'b1;
            end
            mode_d = M_SYMBOL;
            symb   = 1'b1;
          end
        end
        M_SYMBOL: symb = 1'b1;
        default:  disp = 1'b1;
      endcase

      if (symb) begin
        if (sym_next(c) && (cnt_d < TextMax)) begin
          cnt_d = cnt_d + 1'b1;
          res[k[1:0]] = mk_tok(K_SYMBOL, 1'b1, c, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end else begin
          mode_d = M_IDLE;
          res[k[1:0]] = mk_tok(K_SYMBOL, 1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
          disp = 1'b1;
        end
      end

      // start of a fresh token at the current byte
      if (disp) begin
        sl_d  = cl_q;
        sc_d  = cc_q;
        cnt_d = '0;
        dot_d = 1'b0;
        if ((c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf)) begin
          mode_d = mode_d;
        end else if (c == ChSemi) begin
          mode_d = M_COMMENT;
        end else if ((c == ChLParen) || (c == ChRParen) || (c == ChQuote)) begin
          mode_d = M_IDLE;
          res[k[1:0]] = mk_tok((c == ChLParen) ? K_LPAREN :
                               ((c == ChRParen) ? K_RPAREN : K_QUOTE),
                               1'b0, 8'h00, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end else if (c == ChDquote) begin
          mode_d = M_STRING;
        end else if (is_digit(c)) begin
          mode_d = M_NUMBER;
          cnt_d  = cnt_d + 1'b1;
          res[k[1:0]] = mk_tok(K_NUMBER, 1'b1, c, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end else if (c == ChMinus) begin
          mode_d = M_MINUS;
        end else if (sym_first(c)) begin
          mode_d = M_SYMBOL;
          cnt_d  = cnt_d + 1'b1;
          res[k[1:0]] = mk_tok(K_SYMBOL, 1'b1, c, 1'b0, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end else begin
          halt_d = 1'b1;
          mode_d = M_IDLE;
          res[k[1:0]] = mk_tok(K_ERROR, 1'b1, c, 1'b1, PosOutW'(sl_d), PosOutW'(sc_d));
          k = k + 1'b1;
        end
      end

      // saturating position counters
      if (c == ChLf) begin
        if (cl_q != '1) cl_d = cl_q + 1'b1;
        cc_d = POSITION_BITS'(1);
      end else if (cc_q != '1) begin
        cc_d = cc_q + 1'b1;
      end
    end
  end

  assign push_o           = accept && !halt_q && (k != '0);
  assign push_data_o.cnt  = k;
  assign push_data_o.tok  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= '0;
      dot_q  <= 1'b0;
      halt_q <= 1'b0;
      cl_q   <= POSITION_BITS'(1);
      cc_q   <= POSITION_BITS'(1);
      sl_q   <= POSITION_BITS'(1);
      sc_q   <= POSITION_BITS'(1);
    end else if (accept && !halt_q) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      dot_q  <= dot_d;
      halt_q <= halt_d;
      cl_q   <= cl_d;
      cc_q   <= cc_d;
      sl_q   <= sl_d;
      sc_q   <= sc_d;
    end
  end

  a_no_push_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> !push_o)
    else $error("bundle pushed after error halt");

  a_text_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TextMax)
    else $error("text count past cap");

endmodule

// File: rtl/stok_fifo.sv
// ----------------------------------------------------------------------------
// stok_fifo
// Short register queue of result bundles between lexer and output side.
// ----------------------------------------------------------------------------
module stok_fifo import stok_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t pop_data_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);

  bundle_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// File: rtl/stok_back.sv
// ----------------------------------------------------------------------------
// stok_back
// Output side: holds one bundle and hands its results out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module stok_back import stok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  bundle_t q_data_i,
  output logic    q_pop_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output tok_t    out_tok_o
);

  bundle_t                     bun_q;
  logic [$clog2(MaxRes)-1:0]   idx_q;
  logic                        valid_q;
  logic                        take, done;

  assign take        = valid_q && out_ready_i;
  assign done        = take && ({1'b0, idx_q} == (bun_q.cnt - 1'b1));
  assign q_pop_o     = (!valid_q || done) && !q_empty_i;
  assign out_valid_o = valid_q;
  assign out_tok_o   = bun_q.tok[idx_q];

  always_ff @(posedge clk_i) begin
    if (q_pop_o) bun_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (take) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, idx_q} < bun_q.cnt))
    else $error("result index beyond bundle");

endmodule

// File: rtl/sexpr_tokenizer.sv
// ----------------------------------------------------------------------------
// sexpr_tokenizer
// S-expression lexer: source bytes in, token results out.
// ----------------------------------------------------------------------------
// One byte (or the end-of-input mark) is taken per cycle; the lexer state
// is registered as each item is taken, so items can follow back to back.
// Each item gives zero to four results; they are packed into one bundle and
// sent through a two-bundle queue to the output side, which hands out one
// result per cycle while the receiver is ready. Sustained rate is one item
// per cycle while the receiver is ready and items average at most one
// result; input stalls only when the queue is full. The first result of an
// item passes the queue register and then the output bundle register. After
// an error result no further results come until reset.
module sexpr_tokenizer import stok_pkg::*; #(
  parameter int MAX_TEXT      = 255,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic               has_char_o,
  output logic [7:0]         text_char_o,
  output logic               last_o,
  output logic [PosOutW-1:0] line_o,
  output logic [PosOutW-1:0] col_o
);

  logic    push, pop, q_full, q_empty;
  bundle_t push_data, pop_data;
  tok_t    tok;

  stok_front #(
    .MAX_TEXT      (MAX_TEXT),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .in_ready_o     (in_ready_o),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  stok_fifo #(
    .DEPTH (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  stok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_tok_o   (tok)
  );

  assign kind_o      = tok.kind;
  assign has_char_o  = tok.has_char;
  assign text_char_o = tok.text_char;
  assign last_o      = tok.last;
  assign line_o      = tok.line;
  assign col_o       = tok.col;

endmodule
